/* hdl/rti_pkg.sv */
package rti_pkg;

   localparam int CW          = 32;
   localparam int FRAC        = 16;
   localparam int TAGW        = 32;
   localparam int EW          = CW + 1;
   localparam int PW          = 2 * EW + 1;
   localparam int LB          = (PW + 1) / 2;
   localparam int HB          = PW - LB;
   localparam int DW          = EW + PW + 2;
   localparam int QB          = CW - 1;
   localparam int SATSH       = QB - FRAC;
   localparam int BW          = FRAC + 1;
   localparam int EPSW        = 2 * CW - 1;
   localparam int NLANE       = 4;
   localparam int GEOM_STAGES = 6;
   localparam int TEST_STAGES = 3;
   localparam int LATENCY     = 1 + GEOM_STAGES + TEST_STAGES + QB + 1;
   localparam int AW          = 6;
   localparam int DATAW       = 64;

   localparam logic [2:0] REG_ORG_X = 3'd0;
   localparam logic [2:0] REG_ORG_Y = 3'd1;
   localparam logic [2:0] REG_ORG_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X = 3'd3;
   localparam logic [2:0] REG_DIR_Y = 3'd4;
   localparam logic [2:0] REG_DIR_Z = 3'd5;
   localparam logic [2:0] REG_EPS   = 3'd6;

   localparam int LANE_U = 0;
   localparam int LANE_V = 1;
   localparam int LANE_W = 2;
   localparam int LANE_T = 3;

   localparam logic [CW-1:0]   DIR_Z_RESET = CW'(1) << FRAC;
   localparam logic [EPSW-1:0] EPS_RESET   = EPSW'(1);

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [EW-1:0] edge_type;
   typedef logic signed [PW-1:0] cross_type;
   typedef logic signed [DW-1:0] wide_type;

   typedef struct packed {
      coord_type v0_x, v0_y, v0_z;
      coord_type v1_x, v1_y, v1_z;
      coord_type v2_x, v2_y, v2_z;
      logic [TAGW-1:0] tag;
   } tri_type;

   typedef struct packed {
      coord_type org_x, org_y, org_z;
      coord_type dir_x, dir_y, dir_z;
   } ray_type;

   typedef struct packed {
      wide_type det, un, vn, tn;
      logic [TAGW-1:0] tag;
   } dots_type;

   typedef struct packed {
      logic hit;
      logic sat;
      wide_type det, un, vn, wn, tn;
      logic [TAGW-1:0] tag;
   } job_type;

   typedef struct packed {
      logic hit;
      logic sat;
      logic [NLANE-1:0][QB-1:0] quot;
      logic [TAGW-1:0] tag;
   } res_type;

endpackage

/* hdl/rti_geom.sv */
// Edges, cross products and the four dot products, six register stages.
module rti_geom (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rti_pkg::tri_type   in_tri,
   input  rti_pkg::ray_type   ray,
   output logic               out_valid,
   output rti_pkg::dots_type  out_dots
);

   rti_pkg::coord_type v0[3], v1[3], v2[3], org[3];
   rti_pkg::edge_type  dir_e[3];
   logic [rti_pkg::GEOM_STAGES-1:0] vld_ff;
   logic [rti_pkg::TAGW-1:0] tag_ff[rti_pkg::GEOM_STAGES];
   rti_pkg::edge_type  e1_in[3], e2_in[3], s_in[3];
   rti_pkg::edge_type  e1_ff[3][3], e2_ff[3][3], s_ff[3][3];
   logic signed [rti_pkg::PW-2:0] hp_in[6], hp_ff[6], qp_in[6], qp_ff[6];
   rti_pkg::cross_type h_in[3], h_ff[3], q_in[3], q_ff[3];
   rti_pkg::edge_type  pa[12];
   rti_pkg::cross_type pb[12];
   logic signed [rti_pkg::EW+rti_pkg::LB:0]   plo_in[12], plo_ff[12];
   logic signed [rti_pkg::EW+rti_pkg::HB-1:0] phi_in[12], phi_ff[12];
   rti_pkg::wide_type  prod_in[12], prod_ff[12];
   rti_pkg::wide_type  dot_in[4], dot_ff[4];

   always_comb begin
      v0       = '{in_tri.v0_x, in_tri.v0_y, in_tri.v0_z};
      v1       = '{in_tri.v1_x, in_tri.v1_y, in_tri.v1_z};
      v2       = '{in_tri.v2_x, in_tri.v2_y, in_tri.v2_z};
      org      = '{ray.org_x, ray.org_y, ray.org_z};
      dir_e[0] = rti_pkg::edge_type'(ray.dir_x);
      dir_e[1] = rti_pkg::edge_type'(ray.dir_y);
      dir_e[2] = rti_pkg::edge_type'(ray.dir_z);
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = rti_pkg::edge_type'(v1[i]) - rti_pkg::edge_type'(v0[i]);
         e2_in[i] = rti_pkg::edge_type'(v2[i]) - rti_pkg::edge_type'(v0[i]);
         s_in[i]  = rti_pkg::edge_type'(org[i]) - rti_pkg::edge_type'(v0[i]);
      end
   end

   // Cross product terms: h = dir x e2, q = s x e1.
   always_comb begin
      hp_in[0] = dir_e[1] * e2_ff[0][2];
      hp_in[1] = dir_e[2] * e2_ff[0][1];
      hp_in[2] = dir_e[2] * e2_ff[0][0];
      hp_in[3] = dir_e[0] * e2_ff[0][2];
      hp_in[4] = dir_e[0] * e2_ff[0][1];
      hp_in[5] = dir_e[1] * e2_ff[0][0];
      qp_in[0] = s_ff[0][1] * e1_ff[0][2];
      qp_in[1] = s_ff[0][2] * e1_ff[0][1];
      qp_in[2] = s_ff[0][2] * e1_ff[0][0];
      qp_in[3] = s_ff[0][0] * e1_ff[0][2];
      qp_in[4] = s_ff[0][0] * e1_ff[0][1];
      qp_in[5] = s_ff[0][1] * e1_ff[0][0];
      for (int i = 0; i < 3; i++) begin
         h_in[i] = rti_pkg::cross_type'(hp_ff[2*i]) - rti_pkg::cross_type'(hp_ff[2*i+1]);
         q_in[i] = rti_pkg::cross_type'(qp_ff[2*i]) - rti_pkg::cross_type'(qp_ff[2*i+1]);
      end
   end

   // The wide operand of each dot product term is split in two halves.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa[i]   = e1_ff[2][i];
         pb[i]   = h_ff[i];
         pa[3+i] = s_ff[2][i];
         pb[3+i] = h_ff[i];
         pa[6+i] = dir_e[i];
         pb[6+i] = q_ff[i];
         pa[9+i] = e2_ff[2][i];
         pb[9+i] = q_ff[i];
      end
      for (int k = 0; k < 12; k++) begin
         plo_in[k]  = pa[k] * $signed({1'b0, pb[k][rti_pkg::LB-1:0]});
         phi_in[k]  = pa[k] * $signed(pb[k][rti_pkg::PW-1:rti_pkg::LB]);
         prod_in[k] = (rti_pkg::wide_type'(phi_ff[k]) <<< rti_pkg::LB)
                    + rti_pkg::wide_type'(plo_ff[k]);
      end
      for (int d = 0; d < 4; d++) begin
         dot_in[d] = prod_ff[3*d] + prod_ff[3*d+1] + prod_ff[3*d+2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[rti_pkg::GEOM_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tri.tag;
      for (int j = 1; j < rti_pkg::GEOM_STAGES; j++) begin
         tag_ff[j] <= tag_ff[j-1];
      end
      e1_ff[0] <= e1_in;
      e2_ff[0] <= e2_in;
      s_ff[0]  <= s_in;
      for (int j = 1; j < 3; j++) begin
         e1_ff[j] <= e1_ff[j-1];
         e2_ff[j] <= e2_ff[j-1];
         s_ff[j]  <= s_ff[j-1];
      end
      hp_ff   <= hp_in;
      qp_ff   <= qp_in;
      h_ff    <= h_in;
      q_ff    <= q_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      prod_ff <= prod_in;
      dot_ff  <= dot_in;
   end

   assign out_valid    = vld_ff[rti_pkg::GEOM_STAGES-1];
   assign out_dots.det = dot_ff[0];
   assign out_dots.un  = dot_ff[1];
   assign out_dots.vn  = dot_ff[2];
   assign out_dots.tn  = dot_ff[3];
   assign out_dots.tag = tag_ff[rti_pkg::GEOM_STAGES-1];

endmodule

/* hdl/rti_test.sv */
// Sign normalization and the exact range tests, three register stages.
module rti_test (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  rti_pkg::dots_type           in_dots,
   input  logic [rti_pkg::EPSW-1:0]    eps,
   output logic                        out_valid,
   output rti_pkg::job_type            out_job
);

   logic [rti_pkg::TEST_STAGES-1:0] vld_ff;
   logic [rti_pkg::TAGW-1:0] tag_ff[rti_pkg::TEST_STAGES];
   logic neg;
   rti_pkg::wide_type det7_in, un7_in, vn7_in, tn7_in;
   rti_pkg::wide_type det7_ff, un7_ff, vn7_ff, tn7_ff;
   logic [rti_pkg::DW+rti_pkg::SATSH-1:0] tn_x, det_x;
   logic miss8_in, miss8_ff, sat8_in, sat8_ff;
   rti_pkg::wide_type uv8_in, uv8_ff, det8_ff, un8_ff, vn8_ff, tn8_ff;
   logic miss9_in, miss9_ff, sat9_ff;
   rti_pkg::wide_type wn9_in, wn9_ff, det9_ff, un9_ff, vn9_ff, tn9_ff;

   always_comb begin
      neg     = in_dots.det[rti_pkg::DW-1];
      det7_in = neg ? -in_dots.det : in_dots.det;
      un7_in  = neg ? -in_dots.un  : in_dots.un;
      vn7_in  = neg ? -in_dots.vn  : in_dots.vn;
      tn7_in  = neg ? -in_dots.tn  : in_dots.tn;
   end

   always_comb begin
      tn_x     = {{rti_pkg::SATSH{1'b0}}, tn7_ff};
      det_x    = {det7_ff, {rti_pkg::SATSH{1'b0}}};
      miss8_in = (det7_ff == '0)
              || ($unsigned(det7_ff) < {{(rti_pkg::DW-rti_pkg::EPSW){1'b0}}, eps})
              || un7_ff[rti_pkg::DW-1] || (det7_ff < un7_ff)
              || vn7_ff[rti_pkg::DW-1]
              || tn7_ff[rti_pkg::DW-1] || (tn7_ff == '0);
      sat8_in  = tn_x >= det_x;
      uv8_in   = un7_ff + vn7_ff;
      miss9_in = miss8_ff || (det8_ff < uv8_ff);
      wn9_in   = det8_ff - uv8_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[rti_pkg::TEST_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_dots.tag;
      for (int j = 1; j < rti_pkg::TEST_STAGES; j++) begin
         tag_ff[j] <= tag_ff[j-1];
      end
      det7_ff  <= det7_in;
      un7_ff   <= un7_in;
      vn7_ff   <= vn7_in;
      tn7_ff   <= tn7_in;
      miss8_ff <= miss8_in;
      sat8_ff  <= sat8_in;
      uv8_ff   <= uv8_in;
      det8_ff  <= det7_ff;
      un8_ff   <= un7_ff;
      vn8_ff   <= vn7_ff;
      tn8_ff   <= tn7_ff;
      miss9_ff <= miss9_in;
      sat9_ff  <= sat8_ff;
      wn9_ff   <= wn9_in;
      det9_ff  <= det8_ff;
      un9_ff   <= un8_ff;
      vn9_ff   <= vn8_ff;
      tn9_ff   <= tn8_ff;
   end

   assign out_valid   = vld_ff[rti_pkg::TEST_STAGES-1];
   assign out_job.hit = !miss9_ff;
   assign out_job.sat = sat9_ff;
   assign out_job.det = det9_ff;
   assign out_job.un  = un9_ff;
   assign out_job.vn  = vn9_ff;
   assign out_job.wn  = wn9_ff;
   assign out_job.tn  = tn9_ff;
   assign out_job.tag = tag_ff[rti_pkg::TEST_STAGES-1];

endmodule

/* hdl/rti_div.sv */
// Restoring division, one quotient bit per stage, four lanes sharing the divisor.
module rti_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rti_pkg::job_type  in_job,
   output logic              out_valid,
   output rti_pkg::res_type  out_res
);

   logic [rti_pkg::QB-1:0]   vld_ff;
   logic                     hit_ff[rti_pkg::QB], sat_ff[rti_pkg::QB];
   logic [rti_pkg::TAGW-1:0] tag_ff[rti_pkg::QB];
   logic [rti_pkg::DW-1:0]   den_ff[rti_pkg::QB];
   logic [rti_pkg::DW-1:0]   rem_in[rti_pkg::QB][rti_pkg::NLANE];
   logic [rti_pkg::DW-1:0]   rem_ff[rti_pkg::QB][rti_pkg::NLANE];
   logic [rti_pkg::QB-1:0]   xb_in[rti_pkg::QB][rti_pkg::NLANE];
   logic [rti_pkg::QB-1:0]   xb_ff[rti_pkg::QB][rti_pkg::NLANE];
   logic [rti_pkg::QB-1:0]   quo_in[rti_pkg::QB][rti_pkg::NLANE];
   logic [rti_pkg::QB-1:0]   quo_ff[rti_pkg::QB][rti_pkg::NLANE];
   logic [rti_pkg::DW-1:0]   num[rti_pkg::NLANE];
   logic [rti_pkg::DW-1:0]   rem_src, den_src;
   logic [rti_pkg::QB-1:0]   xb_src, quo_src;
   logic [rti_pkg::DW:0]     cand, diff;
   logic                     qbit;

   always_comb begin
      num[rti_pkg::LANE_U] = $unsigned(in_job.un);
      num[rti_pkg::LANE_V] = $unsigned(in_job.vn);
      num[rti_pkg::LANE_W] = $unsigned(in_job.wn);
      num[rti_pkg::LANE_T] = $unsigned(in_job.tn);
      rem_src = '0;
      den_src = '0;
      xb_src  = '0;
      quo_src = '0;
      cand    = '0;
      diff    = '0;
      qbit    = 1'b0;
      for (int j = 0; j < rti_pkg::QB; j++) begin
         for (int l = 0; l < rti_pkg::NLANE; l++) begin
            if (j == 0) begin
               // The numerator is scaled by the fraction bits; the top part
               // seeds the remainder and the rest is shifted in.
               rem_src = num[l] >> rti_pkg::SATSH;
               xb_src  = {num[l][rti_pkg::SATSH-1:0], {rti_pkg::FRAC{1'b0}}};
               quo_src = '0;
               den_src = $unsigned(in_job.det);
            end else begin
               rem_src = rem_ff[j-1][l];
               xb_src  = xb_ff[j-1][l];
               quo_src = quo_ff[j-1][l];
               den_src = den_ff[j-1];
            end
            cand = {rem_src, xb_src[rti_pkg::QB-1]};
            diff = cand - {1'b0, den_src};
            qbit = cand >= {1'b0, den_src};
            rem_in[j][l] = qbit ? diff[rti_pkg::DW-1:0] : cand[rti_pkg::DW-1:0];
            xb_in[j][l]  = xb_src << 1;
            quo_in[j][l] = {quo_src[rti_pkg::QB-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[rti_pkg::QB-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      hit_ff[0] <= in_job.hit;
      sat_ff[0] <= in_job.sat;
      tag_ff[0] <= in_job.tag;
      den_ff[0] <= $unsigned(in_job.det);
      for (int j = 1; j < rti_pkg::QB; j++) begin
         hit_ff[j] <= hit_ff[j-1];
         sat_ff[j] <= sat_ff[j-1];
         tag_ff[j] <= tag_ff[j-1];
         den_ff[j] <= den_ff[j-1];
      end
      rem_ff <= rem_in;
      xb_ff  <= xb_in;
      quo_ff <= quo_in;
   end

   assign out_valid   = vld_ff[rti_pkg::QB-1];
   assign out_res.hit = hit_ff[rti_pkg::QB-1];
   assign out_res.sat = sat_ff[rti_pkg::QB-1];
   assign out_res.tag = tag_ff[rti_pkg::QB-1];
   assign out_res.quot[rti_pkg::LANE_U] = quo_ff[rti_pkg::QB-1][rti_pkg::LANE_U];
   assign out_res.quot[rti_pkg::LANE_V] = quo_ff[rti_pkg::QB-1][rti_pkg::LANE_V];
   assign out_res.quot[rti_pkg::LANE_W] = quo_ff[rti_pkg::QB-1][rti_pkg::LANE_W];
   assign out_res.quot[rti_pkg::LANE_T] = quo_ff[rti_pkg::QB-1][rti_pkg::LANE_T];

endmodule

/* hdl/ray_triangle_intersect.sv */
// Ray/triangle intersection in exact fixed point (Moller-Trumbore). The ray
// lives in the configuration registers; each transaction on the request
// side carries one triangle and a tag, and produces exactly one response
// transaction, hit or miss, in order. The pipeline takes a new triangle in
// every cycle. From the accepting edge to the response strobe, a request
// passes one input register, six stages of edge, cross and dot product
// arithmetic, three stages of range tests, 31 stages of the bit-per-stage
// divider that forms u, v, w and t, and the output register. The divider
// depth, one stage for each bit of the 31-bit distance, makes up most of
// that pipeline. The receiver cannot stall and the pipeline never backs up,
// so busy stays low.
// Configuration may only be written while no transaction is in flight.
module ray_triangle_intersect (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           start,
   output logic                           busy,
   input  logic signed [rti_pkg::CW-1:0]  req_v0_x,
   input  logic signed [rti_pkg::CW-1:0]  req_v0_y,
   input  logic signed [rti_pkg::CW-1:0]  req_v0_z,
   input  logic signed [rti_pkg::CW-1:0]  req_v1_x,
   input  logic signed [rti_pkg::CW-1:0]  req_v1_y,
   input  logic signed [rti_pkg::CW-1:0]  req_v1_z,
   input  logic signed [rti_pkg::CW-1:0]  req_v2_x,
   input  logic signed [rti_pkg::CW-1:0]  req_v2_y,
   input  logic signed [rti_pkg::CW-1:0]  req_v2_z,
   input  logic [rti_pkg::TAGW-1:0]       req_tri_tag,

   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [rti_pkg::QB-1:0]         rsp_hit_distance,
   output logic [rti_pkg::BW-1:0]         rsp_bary_w,
   output logic [rti_pkg::BW-1:0]         rsp_bary_u,
   output logic [rti_pkg::BW-1:0]         rsp_bary_v,
   output logic [rti_pkg::TAGW-1:0]       rsp_result_tag,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rti_pkg::AW-1:0]         paddr,
   input  logic [rti_pkg::DATAW-1:0]      pwdata,
   output logic [rti_pkg::DATAW-1:0]      prdata,
   output logic                           pready
);

   // Configuration registers, one per 8-byte slot.
   rti_pkg::coord_type          org_ff[3], dir_ff[3];
   logic [rti_pkg::EPSW-1:0]    eps_ff;
   logic [2:0]                  reg_idx;
   logic                        cfg_wr;
   rti_pkg::ray_type            ray;

   // Request register in front of the arithmetic.
   logic                        req_vld_ff;
   rti_pkg::tri_type            req_ff;

   logic                        geom_vld, test_vld, div_vld;
   rti_pkg::dots_type           dots;
   rti_pkg::job_type            job;
   rti_pkg::res_type            res;

   // Response register.
   logic                        rsp_vld_ff;
   logic                        hit_ff;
   logic [rti_pkg::QB-1:0]      dist_ff;
   logic [rti_pkg::BW-1:0]      bw_ff, bu_ff, bv_ff;
   logic [rti_pkg::TAGW-1:0]    tag_ff;
   logic [rti_pkg::BW+1:0]      bary_sum;

   assign busy    = 1'b0;
   assign pready  = 1'b1;
   assign reg_idx = paddr[rti_pkg::AW-1:3];
   assign cfg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '{'0, '0, '0};
         dir_ff <= '{'0, '0, rti_pkg::DIR_Z_RESET};
         eps_ff <= rti_pkg::EPS_RESET;
      end else if (cfg_wr) begin
         case (reg_idx)
            rti_pkg::REG_ORG_X: org_ff[0] <= pwdata[rti_pkg::CW-1:0];
            rti_pkg::REG_ORG_Y: org_ff[1] <= pwdata[rti_pkg::CW-1:0];
            rti_pkg::REG_ORG_Z: org_ff[2] <= pwdata[rti_pkg::CW-1:0];
            rti_pkg::REG_DIR_X: dir_ff[0] <= pwdata[rti_pkg::CW-1:0];
            rti_pkg::REG_DIR_Y: dir_ff[1] <= pwdata[rti_pkg::CW-1:0];
            rti_pkg::REG_DIR_Z: dir_ff[2] <= pwdata[rti_pkg::CW-1:0];
            rti_pkg::REG_EPS:   eps_ff    <= pwdata[rti_pkg::EPSW-1:0];
            default: ;
         endcase
      end
   end

   // Coordinates read back as their raw 32-bit pattern, zero-extended.
   always_comb begin
      case (reg_idx)
         rti_pkg::REG_ORG_X: prdata = {{(rti_pkg::DATAW-rti_pkg::CW){1'b0}}, org_ff[0]};
         rti_pkg::REG_ORG_Y: prdata = {{(rti_pkg::DATAW-rti_pkg::CW){1'b0}}, org_ff[1]};
         rti_pkg::REG_ORG_Z: prdata = {{(rti_pkg::DATAW-rti_pkg::CW){1'b0}}, org_ff[2]};
         rti_pkg::REG_DIR_X: prdata = {{(rti_pkg::DATAW-rti_pkg::CW){1'b0}}, dir_ff[0]};
         rti_pkg::REG_DIR_Y: prdata = {{(rti_pkg::DATAW-rti_pkg::CW){1'b0}}, dir_ff[1]};
         rti_pkg::REG_DIR_Z: prdata = {{(rti_pkg::DATAW-rti_pkg::CW){1'b0}}, dir_ff[2]};
         rti_pkg::REG_EPS:   prdata = {{(rti_pkg::DATAW-rti_pkg::EPSW){1'b0}}, eps_ff};
         default:            prdata = '0;
      endcase
   end

   assign ray.org_x = org_ff[0];
   assign ray.org_y = org_ff[1];
   assign ray.org_z = org_ff[2];
   assign ray.dir_x = dir_ff[0];
   assign ray.dir_y = dir_ff[1];
   assign ray.dir_z = dir_ff[2];

   // A request transaction completes whenever start is high, since busy
   // never rises. The payload is captured every cycle; the valid bit says
   // whether it belongs to a real transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_ff.v0_x <= req_v0_x;
      req_ff.v0_y <= req_v0_y;
      req_ff.v0_z <= req_v0_z;
      req_ff.v1_x <= req_v1_x;
      req_ff.v1_y <= req_v1_y;
      req_ff.v1_z <= req_v1_z;
      req_ff.v2_x <= req_v2_x;
      req_ff.v2_y <= req_v2_y;
      req_ff.v2_z <= req_v2_z;
      req_ff.tag  <= req_tri_tag;
   end

   // Edges, h = dir x e2, q = s x e1 and the numerators det, u, v, t.
   rti_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_vld_ff),
      .in_tri    (req_ff),
      .ray       (ray),
      .out_valid (geom_vld),
      .out_dots  (dots)
   );

   // Determinant sign fold, epsilon test and the exact barycentric and
   // distance range tests. Distance saturation is decided here as well, so
   // the divider only ever needs 31 quotient bits.
   rti_test u_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_vld),
      .in_dots   (dots),
      .eps       (eps_ff),
      .out_valid (test_vld),
      .out_job   (job)
   );

   // Four quotients in parallel: u, v, w = 1 - u - v, and t.
   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (test_vld),
      .in_job    (job),
      .out_valid (div_vld),
      .out_res   (res)
   );

   // On a miss every numeric field is zero; the tag always comes through.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= res.hit;
      tag_ff  <= res.tag;
      dist_ff <= !res.hit ? '0 : (res.sat ? '1 : res.quot[rti_pkg::LANE_T]);
      bw_ff   <= res.hit ? res.quot[rti_pkg::LANE_W][rti_pkg::BW-1:0] : '0;
      bu_ff   <= res.hit ? res.quot[rti_pkg::LANE_U][rti_pkg::BW-1:0] : '0;
      bv_ff   <= res.hit ? res.quot[rti_pkg::LANE_V][rti_pkg::BW-1:0] : '0;
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_hit_distance = dist_ff;
   assign rsp_bary_w       = bw_ff;
   assign rsp_bary_u       = bu_ff;
   assign rsp_bary_v       = bv_ff;
   assign rsp_result_tag   = tag_ff;

   assign bary_sum = {2'b00, rsp_bary_w} + {2'b00, rsp_bary_u} + {2'b00, rsp_bary_v};

   // Every accepted request is answered by one response once it has passed the whole pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(rti_pkg::LATENCY) rsp_valid)
      else $error("request did not produce a response at the fixed latency");

   // No response appears without a request at the matching edge.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, rti_pkg::LATENCY))
      else $error("response without a matching request");

   // A miss carries zero distance and zero weights.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_hit_distance == '0) && (rsp_bary_w == '0)
                                  && (rsp_bary_u == '0) && (rsp_bary_v == '0))
      else $error("miss with nonzero result fields");

   // Three truncated weights of a hit add up to one, less at most two units.
   a_bary_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (bary_sum <= ((rti_pkg::BW+2)'(1) << rti_pkg::FRAC))
                              && (bary_sum + (rti_pkg::BW+2)'(2)
                                  >= ((rti_pkg::BW+2)'(1) << rti_pkg::FRAC)))
      else $error("barycentric weights of a hit do not sum to one");

endmodule
